/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL; all use clk and synchronous active-low rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define A2RM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define A2RM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/a2rm_pkg.sv */
// Types, constants and per-stage datapath functions of the axis-angle rotation matrix block.
package a2rm_pkg;

  // Output fraction bits and CORDIC iteration count
  localparam int OUT_FRAC_BITS = 14;
  localparam int TRIG_STEPS    = 16;

  // Inner Q30 format
  localparam int WF = 30;
  localparam logic signed [33:0] PI_W        = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_W   = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [35:0] ONE_W36     = 36'sd1 <<< WF;

  // Entry rounding from Q30 down to OUT_FRAC_BITS
  localparam int ENT_SH   = WF - OUT_FRAC_BITS;
  localparam int ENT_HALF = (ENT_SH == 0) ? 0 : (1 << (ENT_SH - 1));
  localparam logic signed [35:0] ENT_LIM = 36'sd1 <<< OUT_FRAC_BITS;
  localparam logic signed [15:0] ENT_ONE = 16'(ENT_LIM);

  // Pipeline layout
  localparam int NORM_STEPS = 5;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int ST_NORM0   = 1;
  localparam int ST_SQRT0   = ST_NORM0 + NORM_STEPS;
  localparam int ST_PREP    = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_DIV0    = ST_PREP + 1;
  localparam int ST_MUL0    = ST_DIV0 + DIV_STEPS;
  localparam int ST_RND0    = ST_MUL0 + 1;
  localparam int ST_MUL1    = ST_RND0 + 1;
  localparam int ST_SUM     = ST_MUL1 + 1;
  localparam int ST_OUT     = ST_SUM + 1;
  localparam int N_STAGES   = ST_OUT + 1;

  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               zero_axis;
  } out_t;

  // Contents of one pipeline stage register
  typedef struct packed {
    logic             zero;
    logic [2:0]       sgn;
    logic             neg;
    logic [30:0]      mag_x;
    logic [30:0]      mag_y;
    logic [30:0]      mag_z;
    logic [61:0]      nrm;
    logic [62:0]      root;
    logic [61:0]      rem_x;
    logic [61:0]      rem_y;
    logic [61:0]      rem_z;
    logic [30:0]      q_x;
    logic [30:0]      q_y;
    logic [30:0]      q_z;
    logic [33:0]      cx;
    logic [33:0]      cy;
    logic [33:0]      cz;
    logic [31:0]      u_x;
    logic [31:0]      u_y;
    logic [31:0]      u_z;
    logic [33:0]      cosv;
    logic [33:0]      sinv;
    logic [5:0][63:0] prd;
    logic [5:0][33:0] uu;
    logic [34:0]      omc;
    logic [8:0][63:0] trm;
    logic [8:0][35:0] mat;
    logic [8:0][15:0] ent;
  } stg_t;

  // arctan(2^-i) in Q30
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'd843314856;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043836;
      5'd3:  r = 31'd133525158;
      5'd4:  r = 31'd67021686;
      5'd5:  r = 31'd33543515;
      5'd6:  r = 31'd16775850;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194282;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048575;
      5'd11: r = 31'd524287;
      5'd12: r = 31'd262143;
      5'd13: r = 31'd131071;
      5'd14: r = 31'd65535;
      5'd15: r = 31'd32767;
      5'd16: r = 31'd16383;
      5'd17: r = 31'd8191;
      5'd18: r = 31'd4095;
      5'd19: r = 31'd2047;
      5'd20: r = 31'd1023;
      5'd21: r = 31'd511;
      5'd22: r = 31'd255;
      5'd23: r = 31'd127;
      5'd24: r = 31'd63;
      5'd25: r = 31'd31;
      5'd26: r = 31'd15;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      5'd30: r = 31'd1;
      5'd31: r = 31'd0;
    endcase
    return r;
  endfunction

  // Round a Q60 product half up back to Q30
  function automatic logic [33:0] rnd30(input logic [63:0] v);
    logic signed [63:0] t;
    t = $signed(v) + 64'sd536870912;
    return t[63:30];
  endfunction

  // Round Q30 to the output format, clamp to +-1.0, keep the low 16 bits
  function automatic logic [15:0] entry(input logic [35:0] v);
    logic signed [35:0] w;
    w = ($signed(v) + 36'(ENT_HALF)) >>> ENT_SH;
    if (w > ENT_LIM) w = ENT_LIM;
    else if (w < -ENT_LIM) w = -ENT_LIM;
    return w[15:0];
  endfunction

  // First stage: squared norm, magnitudes and angle range reduction
  function automatic stg_t stage_prep(input in_t d);
    stg_t o;
    logic [15:0] mx, my, mz;
    logic [31:0] n2;
    logic signed [33:0] ang;
    o = '0;
    mx = d.axis_x[15] ? 16'(-d.axis_x) : d.axis_x;
    my = d.axis_y[15] ? 16'(-d.axis_y) : d.axis_y;
    mz = d.axis_z[15] ? 16'(-d.axis_z) : d.axis_z;
    n2 = {16'd0, mx} * {16'd0, mx} + {16'd0, my} * {16'd0, my} + {16'd0, mz} * {16'd0, mz};
    o.zero  = (n2 == 32'd0);
    o.sgn   = {d.axis_x[15], d.axis_y[15], d.axis_z[15]};
    o.mag_x = {15'd0, mx};
    o.mag_y = {15'd0, my};
    o.mag_z = {15'd0, mz};
    o.nrm   = {30'd0, n2};
    ang = {d.angle[15], d.angle, 17'd0};
    if (ang > HALF_PI_W) begin
      ang   = ang - PI_W;
      o.neg = 1'b1;
    end else if (ang < -HALF_PI_W) begin
      ang   = ang + PI_W;
      o.neg = 1'b1;
    end
    o.cx = CORDIC_GAIN;
    o.cy = '0;
    o.cz = ang;
    return o;
  endfunction

  // Stage k of the pipeline, k >= 1
  function automatic stg_t stage_step(input int k, input stg_t d);
    stg_t o;
    logic signed [33:0] x, y, z, xs, ys, at;
    logic [4:0] ai;
    int kk, j;
    logic [63:0] bval, nn, rr;
    logic [61:0] dv;
    logic signed [31:0] ux, uy, uz;
    logic [8:0][33:0] rt;
    logic signed [35:0] c36;
    o = d;

    // CORDIC rotation step
    if (k >= 1 && k <= TRIG_STEPS) begin
      ai = 5'((k - 1) & 31);
      x  = $signed(d.cx);
      y  = $signed(d.cy);
      z  = $signed(d.cz);
      xs = x >>> ai;
      ys = y >>> ai;
      at = $signed({3'd0, atan_q30(ai)});
      if (!z[33]) begin
        o.cx = x - ys;
        o.cy = y + xs;
        o.cz = z - at;
      end else begin
        o.cx = x + ys;
        o.cy = y - xs;
        o.cz = z + at;
      end
    end

    // Normalize: shift the norm by 2*kk bits and the magnitudes by kk while the top stays clear
    if (k >= ST_NORM0 && k < ST_NORM0 + NORM_STEPS) begin
      kk = 16 >> (k - ST_NORM0);
      if ((d.nrm >> (62 - 2 * kk)) == 62'd0) begin
        o.nrm   = d.nrm << (2 * kk);
        o.mag_x = d.mag_x << kk;
        o.mag_y = d.mag_y << kk;
        o.mag_z = d.mag_z << kk;
      end
    end

    // Integer square root, one result bit per stage
    if (k >= ST_SQRT0 && k < ST_SQRT0 + SQRT_STEPS) begin
      bval = 64'd1 << (62 - 2 * (k - ST_SQRT0));
      nn   = {2'd0, d.nrm};
      rr   = {1'b0, d.root};
      if (nn >= rr + bval) begin
        nn = nn - (rr + bval);
        rr = (rr >> 1) + bval;
      end else begin
        rr = rr >> 1;
      end
      o.nrm  = nn[61:0];
      o.root = rr[62:0];
    end

    // Divider dividends with half the divisor added for rounding
    if (k == ST_PREP) begin
      o.rem_x = {1'b0, d.mag_x, 30'd0} + {32'd0, d.root[30:1]};
      o.rem_y = {1'b0, d.mag_y, 30'd0} + {32'd0, d.root[30:1]};
      o.rem_z = {1'b0, d.mag_z, 30'd0} + {32'd0, d.root[30:1]};
      o.q_x   = '0;
      o.q_y   = '0;
      o.q_z   = '0;
    end

    // Restoring division, one quotient bit per stage
    if (k >= ST_DIV0 && k < ST_DIV0 + DIV_STEPS) begin
      j  = DIV_STEPS - 1 - (k - ST_DIV0);
      dv = {31'd0, d.root[30:0]} << j;
      if (d.rem_x >= dv) begin
        o.rem_x = d.rem_x - dv;
        o.q_x   = d.q_x | (31'd1 << j);
      end
      if (d.rem_y >= dv) begin
        o.rem_y = d.rem_y - dv;
        o.q_y   = d.q_y | (31'd1 << j);
      end
      if (d.rem_z >= dv) begin
        o.rem_z = d.rem_z - dv;
        o.q_z   = d.q_z | (31'd1 << j);
      end
    end

    // Signed unit axis, final sine/cosine, axis outer products
    if (k == ST_MUL0) begin
      ux = d.sgn[2] ? -$signed({1'b0, d.q_x}) : $signed({1'b0, d.q_x});
      uy = d.sgn[1] ? -$signed({1'b0, d.q_y}) : $signed({1'b0, d.q_y});
      uz = d.sgn[0] ? -$signed({1'b0, d.q_z}) : $signed({1'b0, d.q_z});
      o.u_x = ux;
      o.u_y = uy;
      o.u_z = uz;
      o.cosv = d.neg ? 34'(-$signed(d.cx)) : d.cx;
      o.sinv = d.neg ? 34'(-$signed(d.cy)) : d.cy;
      o.prd[0] = 64'(ux) * 64'(ux);
      o.prd[1] = 64'(uy) * 64'(uy);
      o.prd[2] = 64'(uz) * 64'(uz);
      o.prd[3] = 64'(ux) * 64'(uy);
      o.prd[4] = 64'(ux) * 64'(uz);
      o.prd[5] = 64'(uy) * 64'(uz);
    end

    // Round outer products, one minus cosine
    if (k == ST_RND0) begin
      for (int i = 0; i < 6; i++) o.uu[i] = rnd30(d.prd[i]);
      o.omc = 35'(ONE_W36) - {d.cosv[33], d.cosv};
    end

    // Scale by (1 - cos) and by sin
    if (k == ST_MUL1) begin
      for (int i = 0; i < 6; i++) begin
        o.trm[i] = 64'($signed(d.uu[i])) * 64'($signed(d.omc));
      end
      o.trm[6] = 64'($signed(d.u_x)) * 64'($signed(d.sinv));
      o.trm[7] = 64'($signed(d.u_y)) * 64'($signed(d.sinv));
      o.trm[8] = 64'($signed(d.u_z)) * 64'($signed(d.sinv));
    end

    // Assemble the matrix in Q30; zero axis gives identity
    if (k == ST_SUM) begin
      for (int i = 0; i < 9; i++) rt[i] = rnd30(d.trm[i]);
      c36 = {{2{d.cosv[33]}}, d.cosv};
      o.mat[0] = 36'($signed(rt[0]) + c36);
      o.mat[1] = 36'($signed(rt[3]) - $signed(rt[8]));
      o.mat[2] = 36'($signed(rt[4]) + $signed(rt[7]));
      o.mat[3] = 36'($signed(rt[3]) + $signed(rt[8]));
      o.mat[4] = 36'($signed(rt[1]) + c36);
      o.mat[5] = 36'($signed(rt[5]) - $signed(rt[6]));
      o.mat[6] = 36'($signed(rt[4]) - $signed(rt[7]));
      o.mat[7] = 36'($signed(rt[5]) + $signed(rt[6]));
      o.mat[8] = 36'($signed(rt[2]) + c36);
      if (d.zero) begin
        o.mat    = '0;
        o.mat[0] = ONE_W36;
        o.mat[4] = ONE_W36;
        o.mat[8] = ONE_W36;
      end
    end

    // Output rounding and clamp
    if (k == ST_OUT) begin
      for (int i = 0; i < 9; i++) o.ent[i] = entry(d.mat[i]);
    end
    return o;
  endfunction

endpackage

/* hdl/axis_angle_to_rotation_matrix.sv */
// Top level: pipelined axis-angle to 3x3 rotation matrix with a two-entry output buffer.
// Path: a result is offered once it has passed every stage register and then the buffer.
// Throughput: one item per cycle while the output buffer has room; the 32-stage square root
// and 31-stage divider set the pipeline depth, the CORDIC runs alongside normalize and sqrt.
// Backpressure: the pipeline advances while the output buffer has room.
// Reset (synchronous, rst_n low) clears valid bits and buffer pointers only.
`include "assert_macros.svh"

module axis_angle_to_rotation_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  a2rm_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output a2rm_pkg::out_t    out_data
);

  localparam int NS = a2rm_pkg::N_STAGES;

  a2rm_pkg::stg_t s_r   [NS];
  a2rm_pkg::stg_t s_nxt [NS];
  logic [NS-1:0]  v_r, v_nxt;

  a2rm_pkg::out_t buf_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  logic           advance, push, pop;
  logic           zero_ok;
  a2rm_pkg::out_t res;

  // Pipeline moves as a whole while the buffer is not full
  assign advance = (cnt_r != 2'd2);
  assign in_ready = advance;
  assign push    = advance && v_r[NS-1];
  assign pop     = out_valid && out_ready;

  // Stage datapath
  assign s_nxt[0] = a2rm_pkg::stage_prep(in_data);
  for (genvar k = 1; k < NS; k++) begin : g_stg
    assign s_nxt[k] = a2rm_pkg::stage_step(k, s_r[k-1]);
  end

  always_comb begin
    v_nxt = v_r;
    if (advance) v_nxt = {v_r[NS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NS; k++) s_r[k] <= s_nxt[k];
    end
  end

  // Result item from the last stage
  always_comb begin
    res.m00       = s_r[NS-1].ent[0];
    res.m01       = s_r[NS-1].ent[1];
    res.m02       = s_r[NS-1].ent[2];
    res.m10       = s_r[NS-1].ent[3];
    res.m11       = s_r[NS-1].ent[4];
    res.m12       = s_r[NS-1].ent[5];
    res.m20       = s_r[NS-1].ent[6];
    res.m21       = s_r[NS-1].ent[7];
    res.m22       = s_r[NS-1].ent[8];
    res.zero_axis = s_r[NS-1].zero;
  end

  // Output buffer pointers
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= res;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = buf_r[rp_r];

  // Identity pattern for zero-axis results (diagonal, m01, m12 and m20)
  assign zero_ok = !out_data.zero_axis ||
                   (out_data.m00 == a2rm_pkg::ENT_ONE && out_data.m11 == a2rm_pkg::ENT_ONE &&
                    out_data.m22 == a2rm_pkg::ENT_ONE && out_data.m01 == 16'sd0 &&
                    out_data.m12 == 16'sd0 && out_data.m20 == 16'sd0);

  // Checks
  `A2RM_ASSERT_NEXT(a_in_enters, in_valid && in_ready, v_r[0], "accepted item not in stage 0")
  `A2RM_ASSERT(a_zero_ident, !out_valid || zero_ok, "zero axis result is not identity")
  `A2RM_ASSERT(a_cnt_range, cnt_r != 2'd3, "output buffer count out of range")

endmodule
